/* hw/rtl/sws_pkg.sv */
// Shared types and constants for the sliding window substring search block.
package sws_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
    localparam int LEN_W           = 5;
    localparam int POS_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_end;
    } result_t;

endpackage

/* hw/rtl/sws_cell.sv */
// One window cell: holds a text byte, passes it on, and compares against its pattern byte.
module sws_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sws_pkg::cell_ctrl_t                  ctrl,
    input  logic [7:0]                           byte_in,
    input  logic [sws_pkg::LEN_W-1:0]            len_eff,
    input  logic [sws_pkg::PAT_BYTES-1:0][7:0]   pattern,
    output logic [7:0]                           byte_out,
    output logic                                 hit
);
    import sws_pkg::*;

    localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(CELL_INDEX);

    logic [7:0]       win_reg;
    logic [7:0]       win_next;
    logic [LEN_W-1:0] pat_sel;
    logic             in_use;

    // The head cell always takes the new byte; the others are cleared at a new text.
    always_comb
    begin
        if (ctrl.clear && (CELL_INDEX != 0))
            win_next = '0;
        else
            win_next = byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (ctrl.shift)
            win_reg <= win_next;
    end

    // Cell k holds text byte (len - 1 - k) of a candidate match.
    assign in_use   = CELL_POS < len_eff;
    assign pat_sel  = len_eff - CELL_POS - LEN_W'(1);
    assign hit      = !in_use || (win_next == pattern[pat_sel[PAT_IDX_W-1:0]]);
    assign byte_out = win_reg;

endmodule

/* hw/rtl/sws_out_buf.sv */
// Output register with a skid stage for result words.
module sws_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sws_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_ready,
    output sws_pkg::result_t out_data
);
    import sws_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_fire;

    assign out_fire = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/sliding_window_substring_search.sv */
// Top level of the streaming first-occurrence substring search.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | text_byte, first_of_text, last_of_text
//  out     | out       | out_valid/out_ready  | found, match_end
//
// One text byte word is taken every cycle while the skid stage is empty; its result word
// is registered in the output register, or the skid stage. The rate is set by the cell row:
// each cell shifts and compares its byte, and the match vote and position counter close, together.
// Reset clears the window, the byte position, the done flag and the pattern registers.
// The output register plus a skid stage let one more byte word in while a result word
// waits; input stalls only when both of those hold a result.
module sliding_window_substring_search #(
    parameter int PATTERN_MAX = sws_pkg::PATTERN_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      text_byte,
    input  logic                            first_of_text,
    input  logic                            last_of_text,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [sws_pkg::POS_W-1:0]       match_end
);
    import sws_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PATTERN_MAX);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration registers. Writes are taken in any cycle; an index past the
    // last register is accepted and dropped.
    logic [LEN_W-1:0]               pat_len_reg;
    logic [CFG_DATA_W-1:0]          pat_low_reg;
    logic [CFG_DATA_W-1:0]          pat_high_reg;
    logic [PAT_BYTES-1:0][7:0]      pattern;
    logic [LEN_W-1:0]               len_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg  <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};

    // A length beyond the window is taken as the full window.
    assign len_eff = (pat_len_reg > LEN_CAP) ? LEN_CAP : pat_len_reg;

    // Text tracking state.
    logic [POS_W-1:0] pos_reg;
    logic             done_reg;
    logic [POS_W-1:0] pos_base;
    logic [POS_W-1:0] pos_new;
    logic             done_eff;
    logic             in_fire;
    logic             active;
    logic             skid_full;

    assign in_ready = !skid_full;
    assign in_fire  = in_valid && in_ready;

    // A first-of-text word restarts the position and reopens the search before use.
    assign pos_base = first_of_text ? '0 : pos_reg;
    assign done_eff = first_of_text ? 1'b0 : done_reg;
    assign active   = in_fire && !done_eff;
    assign pos_new  = (pos_base == POS_MAX) ? pos_base : pos_base + POS_W'(1);

    // Row of window cells; cell 0 holds the newest byte.
    cell_ctrl_t                  ctrl;
    logic [PATTERN_MAX-1:0][7:0] cell_bytes;
    logic [PATTERN_MAX-1:0]      hits;

    assign ctrl.shift = active;
    assign ctrl.clear = first_of_text;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [7:0] feed;
            if (k == 0)
            begin : g_head
                assign feed = text_byte;
            end
            else
            begin : g_body
                assign feed = cell_bytes[k-1];
            end

            sws_cell #(
                .CELL_INDEX(k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .byte_in  (feed),
                .len_eff  (len_eff),
                .pattern  (pattern),
                .byte_out (cell_bytes[k]),
                .hit      (hits[k])
            );
        end
    endgenerate

    // Every cell in use must agree, and the text must be long enough to hold
    // the whole pattern. The empty pattern matches at offset zero.
    logic    empty_pat;
    logic    long_enough;
    logic    window_match;
    logic    produce;
    result_t res;

    assign empty_pat    = (len_eff == '0);
    assign long_enough  = pos_new >= {{(POS_W-LEN_W){1'b0}}, len_eff};
    assign window_match = (&hits) && long_enough;
    assign produce      = active && (empty_pat || window_match || last_of_text);

    always_comb
    begin
        if (empty_pat)
        begin
            res.found     = 1'b1;
            res.match_end = '0;
        end
        else if (window_match)
        begin
            res.found     = 1'b1;
            res.match_end = pos_new;
        end
        else
        begin
            res.found     = 1'b0;
            res.match_end = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (active)
            begin
                pos_reg  <= pos_new;
                done_reg <= produce;
            end
            else
            begin
                pos_reg  <= pos_base;
                done_reg <= done_eff;
            end
        end
    end

    result_t out_data;

    sws_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (produce),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign found     = out_data.found;
    assign match_end = out_data.match_end;

    // A new result word only ever follows an accepted text byte.
    a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result word appeared without an accepted text byte");

    // Once a result is given, the search for this text is closed.
    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> done_reg)
        else $error("search not closed after a result");

    // Within one text the byte position never moves backward.
    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !first_of_text) |=> (pos_reg >= $past(pos_reg)))
        else $error("byte position went backward within a text");

    // A found result with a non-empty pattern ends no earlier than the pattern length.
    a_match_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && window_match && !empty_pat) |-> (res.match_end >= POS_W'(len_eff)))
        else $error("match end shorter than the pattern");

endmodule
